// ===== rtl/tmd_pkg.sv =====
// Shared constants and types for the trimmed mean decimator.
// No dependencies; used by every module of the block.
`default_nettype none

package tmd_pkg;

  localparam int NUM_CH      = 6;
  localparam int SAMPLE_W    = 12;
  localparam int SAMPLE_MAX  = 4095;
  localparam int DEF_SAMPLES = 10;

  // Per-item control that the top level broadcasts to every lane
  typedef struct packed {
    logic accept;  // an item is taken this cycle
    logic first;   // item opens a window
    logic last;    // item closes a window
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/trimmed_mean_decimator.sv =====
// Top level of the trimmed mean decimator: window counter, six channel
// lanes and the merging divider. Uses tmd_pkg, tmd_lane and tmd_merge.
`default_nettype none

// Each input item is one snapshot of six 12-bit channels. Every SAMPLES
// items form a window; for each channel the window sum, minimum and maximum
// are tracked in its own lane, one item per clock while s_tready is high.
// On the closing item of a window the lanes capture sum - max - min, and
// the merging stage divides each by SAMPLES-2 (reciprocal multiply, then
// one correction step) and emits the six trimmed means as one output item;
// all other items give no output. The block takes one item every cycle
// while s_tready is high. The closing item's trimmed sums are registered in
// the lanes, then pass the divider's estimate register and the output
// register. s_tready drops only on a window's closing item while the
// previous window's trimmed sums still wait behind a stalled output, so with
// m_tready held high the input never stalls. SAMPLES ranges from 3 to 32.
module trimmed_mean_decimator #(
  parameter int SAMPLES = tmd_pkg::DEF_SAMPLES
) (
  input  wire                                           clk,
  input  wire                                           rst,
  input  wire                                           s_tvalid,
  output logic                                          s_tready,
  // s_tdata, from bit 0 up: sample_ch0 .. sample_ch5, 12 bits each
  input  wire logic [tmd_pkg::NUM_CH*tmd_pkg::SAMPLE_W-1:0] s_tdata,
  output logic                                          m_tvalid,
  input  wire                                           m_tready,
  // m_tdata, from bit 0 up: mean_ch0 .. mean_ch5, 12 bits each
  output logic [tmd_pkg::NUM_CH*tmd_pkg::SAMPLE_W-1:0]  m_tdata
);

  localparam int SUM_W = $clog2(SAMPLES * tmd_pkg::SAMPLE_MAX + 1);
  localparam int CNT_W = $clog2(SAMPLES);

  logic [CNT_W-1:0]   window_count;
  logic [CNT_W-1:0]   window_count_next;
  logic               last;
  logic               accept;
  logic               stage_full;
  tmd_pkg::lane_ctl_t ctl;

  logic [tmd_pkg::NUM_CH-1:0][SUM_W-1:0] trim;

  assign last     = (window_count == CNT_W'(SAMPLES - 1));
  // Hold off a closing item only while the lane sums are still waiting
  assign s_tready = !(last && stage_full);
  assign accept   = s_tvalid && s_tready;

  assign ctl.accept = accept;
  assign ctl.first  = (window_count == '0);
  assign ctl.last   = last;

  // Advance through the window, wrap after the closing item
  assign window_count_next = last ? '0 : window_count + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
    end else if (accept) begin
      window_count <= window_count_next;
    end
  end

  for (genvar c = 0; c < tmd_pkg::NUM_CH; c++) begin : g_lane
    tmd_lane #(
      .SAMPLES (SAMPLES)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .sample (s_tdata[c*tmd_pkg::SAMPLE_W +: tmd_pkg::SAMPLE_W]),
      .trim   (trim[c])
    );
  end

  tmd_merge #(
    .SAMPLES (SAMPLES)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && last),
    .trim       (trim),
    .stage_full (stage_full),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  // Counter stays inside the window
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    window_count <= CNT_W'(SAMPLES - 1))
    else $error("window count out of range");

  // Closing item wraps the window
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> (window_count == '0))
    else $error("window did not restart after closing item");

  // Other items step the counter by one
  a_step: assert property (@(posedge clk) disable iff (rst)
    (accept && !last) |=> (window_count == $past(window_count) + CNT_W'(1)))
    else $error("window count did not advance");

  // Input stalls only on a closing item
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (last && stage_full))
    else $error("input stalled outside a closing item");

endmodule

`default_nettype wire

// ===== rtl/tmd_lane.sv =====
// One channel lane: running sum, minimum and maximum over the window,
// and the trimmed sum captured on the closing item. Uses tmd_pkg.
`default_nettype none

module tmd_lane #(
  parameter int SAMPLES = tmd_pkg::DEF_SAMPLES,
  localparam int SUM_W  = $clog2(SAMPLES * tmd_pkg::SAMPLE_MAX + 1)
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire tmd_pkg::lane_ctl_t           ctl,
  input  wire logic [tmd_pkg::SAMPLE_W-1:0] sample,
  output logic [SUM_W-1:0]                  trim
);

  logic [SUM_W-1:0]             sum;
  logic [SUM_W-1:0]             sum_next;
  logic [tmd_pkg::SAMPLE_W-1:0] mn;
  logic [tmd_pkg::SAMPLE_W-1:0] mn_next;
  logic [tmd_pkg::SAMPLE_W-1:0] mx;
  logic [tmd_pkg::SAMPLE_W-1:0] mx_next;
  logic [SUM_W-1:0]             trim_next;

  // First item of a window reloads all three trackers
  always_comb begin
    if (ctl.first) begin
      sum_next = SUM_W'(sample);
      mn_next  = sample;
      mx_next  = sample;
    end else begin
      sum_next = sum + SUM_W'(sample);
      mn_next  = (sample < mn) ? sample : mn;
      mx_next  = (sample > mx) ? sample : mx;
    end
    trim_next = sum_next - SUM_W'(mx_next) - SUM_W'(mn_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctl.accept) begin
      sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      mn <= mn_next;
      mx <= mx_next;
    end
    if (ctl.accept && ctl.last) begin
      trim <= trim_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tmd_merge.sv =====
// Merging stage: takes the six trimmed sums, divides each by SAMPLES-2
// through a reciprocal multiply with one correction step, and holds the
// packed result in the output register. Uses tmd_pkg.
`default_nettype none

module tmd_merge #(
  parameter int SAMPLES = tmd_pkg::DEF_SAMPLES,
  localparam int SUM_W  = $clog2(SAMPLES * tmd_pkg::SAMPLE_MAX + 1)
) (
  input  wire                                           clk,
  input  wire                                           rst,
  input  wire                                           load,
  input  wire logic [tmd_pkg::NUM_CH-1:0][SUM_W-1:0]    trim,
  output logic                                          stage_full,
  output logic                                          m_tvalid,
  input  wire                                           m_tready,
  // m_tdata, from bit 0 up: mean_ch0 .. mean_ch5, 12 bits each
  output logic [tmd_pkg::NUM_CH*tmd_pkg::SAMPLE_W-1:0]  m_tdata
);

  localparam int DIV    = SAMPLES - 2;
  localparam int PROD_W = 2 * SUM_W + 1;
  localparam logic [SUM_W:0] RECIP = (SUM_W+1)'((1 << SUM_W) / DIV);

  logic v1;
  logic v2;
  logic move1;
  logic move2;

  logic [tmd_pkg::NUM_CH-1:0][SUM_W-1:0]             trim2;
  logic [tmd_pkg::NUM_CH-1:0][tmd_pkg::SAMPLE_W-1:0] qe;
  logic [tmd_pkg::NUM_CH-1:0][tmd_pkg::SAMPLE_W-1:0] mean;

  // Advance a stage when it holds data and the one after it frees up
  assign move2      = v2 && (!m_tvalid || m_tready);
  assign move1      = v1 && (!v2 || move2);
  assign stage_full = v1 && !move1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        v1 <= 1'b1;
      end else if (move1) begin
        v1 <= 1'b0;
      end
      if (move1) begin
        v2 <= 1'b1;
      end else if (move2) begin
        v2 <= 1'b0;
      end
      if (move2) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  for (genvar c = 0; c < tmd_pkg::NUM_CH; c++) begin : g_ch
    logic [PROD_W-1:0]            prod;
    logic [SUM_W-1:0]             qd;
    logic [SUM_W-1:0]             rem;
    logic                         fix;

    // Estimate falls at most one below the true quotient
    assign prod = PROD_W'(trim[c]) * PROD_W'(RECIP);
    assign qd   = SUM_W'(qe[c]) * SUM_W'(DIV);
    assign rem  = trim2[c] - qd;
    assign fix  = (rem >= SUM_W'(DIV));

    always_ff @(posedge clk) begin
      if (move1) begin
        trim2[c] <= trim[c];
        qe[c]    <= prod[SUM_W +: tmd_pkg::SAMPLE_W];
      end
      if (move2) begin
        mean[c] <= qe[c] + tmd_pkg::SAMPLE_W'(fix);
      end
    end

    assign m_tdata[c*tmd_pkg::SAMPLE_W +: tmd_pkg::SAMPLE_W] = mean[c];
  end

endmodule

`default_nettype wire
